@@ sv/rrhw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrhw_pkg
// Shared types and constants of the receive ring header walker: the item and
// result payloads, the configuration set, the ring write port and the codes.
// ----------------------------------------------------------------------------
package rrhw_pkg;

  localparam int ADDR_W     = 13;
  localparam int RING_BYTES = 1 << ADDR_W;
  localparam int MAX_BUDGET = 32;

  localparam logic [15:0] ACK_ZERO     = 16'hFFF0;
  localparam logic [15:0] STATUS_OK    = 16'h0001;
  localparam logic [ADDR_W-1:0] ACK_OFFSET = ADDR_W'(16);

  localparam logic [11:0] MIN_FRAME_RESET = 12'd14;
  localparam logic [11:0] MAX_FRAME_RESET = 12'd1518;
  localparam logic [5:0]  BUDGET_RESET    = 6'd32;

  typedef enum logic [1:0] {
    CFG_MIN_FRAME = 2'd0,
    CFG_MAX_FRAME = 2'd1,
    CFG_BUDGET    = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    STOP_CAUGHT_UP = 3'd0,
    STOP_BUDGET    = 3'd1,
    STOP_NO_OK     = 3'd2,
    STOP_BAD_LEN   = 3'd3,
    STOP_SKIPPED   = 3'd4
  } stop_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SKIP_RD,
    ST_SKIP_CHK,
    ST_CHECK,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3
  } walk_state_t;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        byte_value;
    logic [ADDR_W-1:0] write_pointer;
    logic [15:0]       acknowledge_value;
  } item_t;

  typedef struct packed {
    logic              last;
    logic [ADDR_W-1:0] packet_position;
    logic [11:0]       packet_length;
    logic [15:0]       packet_status;
    logic [ADDR_W-1:0] new_acknowledge;
    logic [5:0]        packets_done;
    logic [2:0]        stop_reason;
  } result_t;

  typedef struct packed {
    logic [11:0] min_frame_length;
    logic [11:0] max_frame_length;
    logic [5:0]  packet_budget;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ring_wr_t;

endpackage

@@ sv/rrhw_ring_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrhw_ring_mem
// Byte-wide receive ring: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rrhw_ring_mem (
  input  logic                         clk,
  input  rrhw_pkg::ring_wr_t           wr,
  input  logic [rrhw_pkg::ADDR_W-1:0]  raddr,
  output logic [7:0]                   rdata
);
  import rrhw_pkg::*;

  logic [7:0] mem [RING_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/rrhw_walker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrhw_walker
// Sequencer that clears the ring after reset, stores ring bytes, and walks
// packet headers one byte read per cycle for a service request.
// ----------------------------------------------------------------------------
module rrhw_walker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  rrhw_pkg::item_t              item,
  input  rrhw_pkg::cfg_t               cfg,
  input  logic [7:0]                   rdata,
  output logic                         busy,
  output rrhw_pkg::ring_wr_t           wr,
  output logic [rrhw_pkg::ADDR_W-1:0]  raddr,
  output logic                         result_valid,
  output rrhw_pkg::result_t            result
);
  import rrhw_pkg::*;

  walk_state_t       state, state_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic [ADDR_W-1:0] pos, pos_next;
  logic [ADDR_W-1:0] wp, wp_next;
  logic [5:0]        done, done_next;
  logic [15:0]       status, status_next;
  logic [7:0]        len_lo, len_lo_next;
  logic              result_valid_next;
  result_t           result_next;

  logic [ADDR_W-1:0] start_pos;
  logic [5:0]        budget;
  logic [15:0]       len;
  logic [ADDR_W-1:0] advance;

  function automatic result_t final_result(input logic [ADDR_W-1:0] p,
                                           input logic [5:0] n,
                                           input stop_t why);
    result_t r;
    r                 = '0;
    r.last            = 1'b1;
    r.new_acknowledge = p - ACK_OFFSET;
    r.packets_done    = n;
    r.stop_reason     = why;
    return r;
  endfunction

  assign busy      = (state != ST_IDLE);
  assign start_pos = (item.acknowledge_value == ACK_ZERO) ? '0
                     : item.acknowledge_value[ADDR_W-1:0] + ACK_OFFSET;
  assign budget    = (cfg.packet_budget > 6'(MAX_BUDGET)) ? 6'(MAX_BUDGET)
                     : cfg.packet_budget;
  assign len       = {rdata, len_lo};
  // Header plus payload, rounded up to the next 4-byte boundary.
  assign advance   = (len[ADDR_W-1:0] + ADDR_W'(7)) & ~ADDR_W'(3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      clr_addr     <= clr_addr_next;
      result_valid <= result_valid_next;
    end
    pos    <= pos_next;
    wp     <= wp_next;
    done   <= done_next;
    status <= status_next;
    len_lo <= len_lo_next;
    result <= result_next;
  end

  always_comb begin
    state_next        = state;
    clr_addr_next     = clr_addr;
    pos_next          = pos;
    wp_next           = wp;
    done_next         = done;
    status_next       = status;
    len_lo_next       = len_lo;
    result_valid_next = 1'b0;
    result_next       = result;
    wr                = '0;
    raddr             = pos;

    unique case (state)
      ST_CLEAR: begin
        wr.en         = 1'b1;
        wr.addr       = clr_addr;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start && !item.mode) begin
          wr.en   = 1'b1;
          wr.addr = item.byte_address;
          wr.data = item.byte_value;
        end else if (start) begin
          wp_next   = item.write_pointer;
          pos_next  = start_pos;
          done_next = '0;
          if (start_pos == '0 && item.write_pointer != '0) begin
            state_next = ST_SKIP_RD;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_SKIP_RD: begin
        raddr      = '0;
        state_next = ST_SKIP_CHK;
      end
      ST_SKIP_CHK: begin
        // Nothing valid at the ring start: resynchronize to the write pointer.
        if ((rdata & STATUS_OK[7:0]) == '0) begin
          result_valid_next = 1'b1;
          result_next       = final_result(wp, '0, STOP_SKIPPED);
          state_next        = ST_IDLE;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (pos == wp) begin
          result_valid_next = 1'b1;
          result_next       = final_result(pos, done, STOP_CAUGHT_UP);
          state_next        = ST_IDLE;
        end else if (done >= budget) begin
          result_valid_next = 1'b1;
          result_next       = final_result(pos, done, STOP_BUDGET);
          state_next        = ST_IDLE;
        end else begin
          raddr      = pos;
          state_next = ST_RD0;
        end
      end
      ST_RD0: begin
        status_next[7:0] = rdata;
        raddr            = pos + ADDR_W'(1);
        state_next       = ST_RD1;
      end
      ST_RD1: begin
        status_next[15:8] = rdata;
        raddr             = pos + ADDR_W'(2);
        state_next        = ST_RD2;
      end
      ST_RD2: begin
        len_lo_next = rdata;
        raddr       = pos + ADDR_W'(3);
        state_next  = ST_RD3;
      end
      ST_RD3: begin
        result_valid_next = 1'b1;
        if ((status & STATUS_OK) == '0) begin
          result_next = final_result(pos, done, STOP_NO_OK);
          state_next  = ST_IDLE;
        end else if (len < {4'd0, cfg.min_frame_length} ||
                     len > {4'd0, cfg.max_frame_length}) begin
          result_next = final_result(pos, done, STOP_BAD_LEN);
          state_next  = ST_IDLE;
        end else begin
          result_next                 = '0;
          result_next.packet_position = pos;
          result_next.packet_length   = len[11:0];
          result_next.packet_status   = status;
          result_next.packets_done    = done + 6'd1;
          done_next                   = done + 6'd1;
          pos_next                    = pos + advance;
          state_next                  = ST_CHECK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/receive_ring_header_walker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// receive_ring_header_walker
// Receive byte ring with a header walker that reports each good packet and
// a summary transaction carrying the new acknowledge position.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. Mode 0 stores one
//   byte in the ring in that cycle and busy stays low, so byte writes can
//   arrive every cycle. Mode 1 is a service request: busy rises and the walker
//   reads the ring through its single memory read port, one byte a cycle.
//   Each header examined takes a position check plus four header byte reads.
//   A request stops at a position check (caught up or budget) or on a bad
//   header after its four reads. When the ring start must be checked, a read
//   of the start byte and its check come first, and a skip ends after them.
//   Each result transaction is shown on result for one cycle with
//   result_valid; the final one, marked by result.last, comes in the first
//   cycle after busy falls. The receiver cannot stall, so results never wait.
//   Configuration writes on cfg_valid/cfg_ready are taken every cycle and
//   belong only in idle periods.
//   After reset the ring is cleared by a pass over all 8192 bytes, one byte
//   per cycle, during which busy is high and no item is taken.
// ----------------------------------------------------------------------------
module receive_ring_header_walker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  rrhw_pkg::item_t              item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [11:0]                  cfg_data,
  output logic                         result_valid,
  output rrhw_pkg::result_t            result
);
  import rrhw_pkg::*;

  cfg_t              cfg;
  ring_wr_t          wr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_frame_length <= MIN_FRAME_RESET;
      cfg.max_frame_length <= MAX_FRAME_RESET;
      cfg.packet_budget    <= BUDGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_FRAME: cfg.min_frame_length <= cfg_data;
        CFG_MAX_FRAME: cfg.max_frame_length <= cfg_data;
        CFG_BUDGET:    cfg.packet_budget    <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  rrhw_ring_mem u_ring (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  rrhw_walker u_walker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .cfg          (cfg),
    .rdata        (rdata),
    .busy         (busy),
    .wr           (wr),
    .raddr        (raddr),
    .result_valid (result_valid),
    .result       (result)
  );

  // A packet transaction is always followed by more of the same request.
  a_packet_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("packet result outside a service request");

  a_done_bounded: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.packets_done <= 6'(MAX_BUDGET))
    else $error("packet count above budget limit");

  a_skip_summary: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.stop_reason == 3'(STOP_SKIPPED)
      |-> result.last && result.packets_done == '0)
    else $error("skip summary carries packets");

  a_service_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.mode |=> busy)
    else $error("service request did not start a walk");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the receive ring header walker. It fills the ring
// with chains of packet headers through byte write transactions, then
// requests a service that walks them. A tracker keeps its own ring image and
// predicts every packet report and the closing summary. The bench runs the
// directed corner cases first, then random traffic under several register
// settings and sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;
  import rrhw_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  class header_walk_tracker;
    bit [7:0]    ring [RING_BYTES];
    logic [12:0] walk_position = '0;
    logic [5:0]  taken = '0;
    logic [11:0] min_len = MIN_FRAME_RESET;
    logic [11:0] max_len = MAX_FRAME_RESET;
    logic [5:0]  quota = BUDGET_RESET;
    result_t     due_reports[$];
    int          fails = 0;

    function int pending();
      return due_reports.size();
    endfunction

    function void set_register(logic [1:0] idx, logic [11:0] val);
      case (idx)
        CFG_MIN_FRAME: min_len = val;
        CFG_MAX_FRAME: max_len = val;
        CFG_BUDGET:    quota = val[5:0];
        default: ;
      endcase
    endfunction

    // Little-endian 16-bit word; the second byte wraps round the ring.
    function logic [15:0] word_at(logic [12:0] at);
      logic [12:0] nxt;
      nxt = at + 13'd1;
      return {ring[nxt], ring[at]};
    endfunction

    function void post(logic last, logic [12:0] ppos, logic [11:0] plen,
                       logic [15:0] pstat, logic [12:0] nack, logic [5:0] done,
                       stop_t why);
      result_t r;
      r.last            = last;
      r.packet_position = ppos;
      r.packet_length   = plen;
      r.packet_status   = pstat;
      r.new_acknowledge = nack;
      r.packets_done    = done;
      r.stop_reason     = why;
      due_reports.push_back(r);
    endfunction

    function void note_item(item_t it);
      logic [12:0] wp, pos;
      logic [15:0] st, ln;
      logic [5:0]  done, lim;
      stop_t       why;
      if (it.mode == 1'b0) begin
        ring[it.byte_address] = it.byte_value;
        return;
      end
      wp  = it.write_pointer;
      pos = (it.acknowledge_value == ACK_ZERO) ? '0 : it.acknowledge_value[12:0] + ACK_OFFSET;
      if (pos == '0 && wp != '0 && ring[0][0] == 1'b0) begin
        walk_position = wp;
        taken         = '0;
        post(1'b1, '0, '0, '0, wp - ACK_OFFSET, '0, STOP_SKIPPED);
        return;
      end
      lim  = (quota > MAX_BUDGET) ? 6'(MAX_BUDGET) : quota;
      done = '0;
      forever begin
        if (pos == wp) begin
          why = STOP_CAUGHT_UP;
          break;
        end
        if (done >= lim) begin
          why = STOP_BUDGET;
          break;
        end
        st = word_at(pos);
        ln = word_at(pos + 13'd2);
        if (st[0] == 1'b0) begin
          why = STOP_NO_OK;
          break;
        end
        if (ln < min_len || ln > max_len) begin
          why = STOP_BAD_LEN;
          break;
        end
        done++;
        // Packet reports carry a zero stop reason.
        post(1'b0, pos, ln[11:0], st, '0, done, STOP_CAUGHT_UP);
        pos = pos + 13'((32'(ln) + 32'd7) & ~32'd3);
      end
      walk_position = pos;
      taken         = done;
      post(1'b1, '0, '0, '0, pos - ACK_OFFSET, done, why);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        fails++;
      end
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (due_reports.size() == 0) begin
        $error("result transaction with nothing expected: %h", got);
        fails++;
        return;
      end
      want = due_reports.pop_front();
      check_field("last", 16'(want.last), 16'(got.last));
      check_field("packet_position", 16'(want.packet_position),
                  16'(got.packet_position));
      check_field("packet_length", 16'(want.packet_length), 16'(got.packet_length));
      check_field("packet_status", want.packet_status, got.packet_status);
      check_field("new_acknowledge", 16'(want.new_acknowledge),
                  16'(got.new_acknowledge));
      check_field("packets_done", 16'(want.packets_done), 16'(got.packets_done));
      check_field("stop_reason", 16'(want.stop_reason), 16'(got.stop_reason));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  item_t       item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;
  logic        result_valid;
  result_t     result;

  header_walk_tracker tracker = new;
  int idle_pct = 0;
  int sent = 0;

  receive_ring_header_walker dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      tracker.check_report(result);
    end
  end

  // The unused fields of each item are filled with noise.
  function automatic item_t ring_write(logic [12:0] at, logic [7:0] val);
    item_t       it;
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    it = noise[$bits(item_t)-1:0];
    it.mode         = 1'b0;
    it.byte_address = at;
    it.byte_value   = val;
    return it;
  endfunction

  function automatic item_t service_request(logic [12:0] wp, logic [15:0] ack);
    item_t       it;
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    it = noise[$bits(item_t)-1:0];
    it.mode              = 1'b1;
    it.write_pointer     = wp;
    it.acknowledge_value = ack;
    return it;
  endfunction

  // Any acknowledge whose low 13 bits sit 16 below the start selects it.
  function automatic logic [15:0] ack_for(logic [12:0] head);
    logic [12:0] low;
    low = head - ACK_OFFSET;
    if (head == '0 && $urandom_range(2) == 0) return ACK_ZERO;
    return {3'($urandom), low};
  endfunction

  function automatic logic [12:0] pick_start();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return 13'($urandom_range(RING_BYTES - 1, RING_BYTES - 16));
    return 13'($urandom);
  endfunction

  function automatic logic [15:0] pick_length();
    int unsigned lo, hi, r;
    lo = tracker.min_len;
    hi = tracker.max_len;
    r  = $urandom_range(99);
    if (lo <= hi && r < 85) begin
      if (r < 10) return 16'(lo);
      if (r < 20) return 16'(hi);
      return 16'($urandom_range(hi, lo));
    end
    if (lo > 0 && r[0]) return 16'(lo - 1);
    if (r[1]) return 16'($urandom_range(65535, hi + 1));
    return 16'(hi + 1);
  endfunction

  task automatic send_item(input item_t it);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_item(it);
    sent++;
  endtask

  task automatic put_word(input logic [12:0] at, input logic [15:0] w);
    send_item(ring_write(at, w[7:0]));
    send_item(ring_write(at + 13'd1, w[15:8]));
  endtask

  // Holds the sender back until every report is in and the walker is idle.
  task automatic settle();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_register(idx, val);
  endtask

  task automatic apply_settings(input logic [11:0] lo, input logic [11:0] hi,
                                input logic [5:0] budget, input bit poke_unused);
    write_reg(CFG_MIN_FRAME, lo);
    write_reg(CFG_MAX_FRAME, hi);
    write_reg(CFG_BUDGET, {6'($urandom), budget});
    if (poke_unused) write_reg(CFG_UNUSED, 12'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // A chain of headers, sometimes broken by a bad status or length, then a
  // service request that starts at its head.
  task automatic run_chain();
    logic [12:0] head, at, wp;
    logic [15:0] stat, len;
    int          n;
    head = pick_start();
    at   = head;
    n    = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      stat    = 16'($urandom);
      stat[0] = ($urandom_range(14) != 0);
      len     = pick_length();
      put_word(at, stat);
      put_word(at + 13'd2, len);
      at = at + 13'((32'(len) + 32'd7) & ~32'd3);
    end
    wp = ($urandom_range(9) < 6) ? at : 13'($urandom);
    send_item(service_request(wp, ack_for(head)));
  endtask

  task automatic run_directed();
    send_item(service_request(13'd0, ACK_ZERO));
    send_item(service_request(13'h1FFF, ACK_ZERO));
    send_item(service_request(13'h0100, 16'h1FF0));
    // Two good packets at the ring start, then an empty header.
    put_word(13'd0, 16'h8001);
    put_word(13'd2, 16'd14);
    put_word(13'd20, 16'hFFFF);
    put_word(13'd22, 16'd1518);
    send_item(service_request(13'h1000, ACK_ZERO));
    send_item(service_request(13'd20, ACK_ZERO));
    // A length one short of the minimum.
    send_item(ring_write(13'd1544, 8'h01));
    send_item(ring_write(13'd1546, 8'h0D));
    send_item(service_request(13'd0, 16'd1528));
    // A header that wraps past the end of the ring.
    send_item(ring_write(13'd8190, 8'h01));
    send_item(ring_write(13'd0, 8'h20));
    send_item(ring_write(13'd1, 8'h00));
    send_item(service_request(13'd34, 16'd8174));
    send_item(service_request(13'd5, ACK_ZERO));
  endtask

  initial begin
    int unsigned lo_tab [6];
    int unsigned hi_tab [6];
    int unsigned bud_tab [6];
    int unsigned idle_tab [6];
    int          goal;
    int unsigned r;
    lo_tab    = '{14, 0, 0, 4095, 200, 0};
    hi_tab    = '{1518, 4095, 64, 4095, 100, 0};
    bud_tab   = '{32, 63, 1, 0, 5, 0};
    idle_tab  = '{0, 88, 16, 0, 88, 16};
    rst       <= 1'b1;
    start     <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    lo_tab[5]  = $urandom_range(200);
    hi_tab[5]  = $urandom_range(2000);
    bud_tab[5] = $urandom_range(63);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    settle();
    for (int p = 0; p < 6; p++) begin
      apply_settings(12'(lo_tab[p]), 12'(hi_tab[p]), 6'(bud_tab[p]), p == 1);
      idle_pct = idle_tab[p];
      goal = sent + 38;
      while (sent < goal) begin
        r = $urandom_range(99);
        if (r < 75) begin
          run_chain();
        end else if (r < 90) begin
          send_item(ring_write(13'($urandom), 8'($urandom)));
        end else begin
          send_item(service_request(13'($urandom), 16'($urandom)));
        end
        if ($urandom_range(19) == 0) settle();
      end
      settle();
    end
    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
